// ===== rtl/omlf_pkg.sv =====
// Shared types and constants of the outlier median low-pass filter.
`default_nettype none

package omlf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FILT_W   = 24;
  localparam int THR_W    = 16;
  localparam int ALPHA_W  = 17;
  localparam int FRAC_SH  = 16;
  localparam int ACC_W    = 41;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h10000;
  localparam logic [ACC_W-1:0]   ROUND_HALF = 41'h8000;

  localparam logic [THR_W-1:0]   THR_RESET   = 16'd500;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd16384;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_ALPHA     = 1'b1;

  typedef struct packed {
    logic load;
    logic cmp;
    logic rot;
  } omlf_sort_ctl_t;

  typedef struct packed {
    logic                start;
    logic [ALPHA_W-1:0]  alpha;
    logic [SAMPLE_W-1:0] median;
    logic [FILT_W-1:0]   prev;
  } omlf_blend_req_t;

endpackage

`default_nettype wire

// ===== rtl/outlier_median_lowpass_filter.sv =====
// Top level: sequencer, configuration registers and output register.
//
// channel  direction  tdata                   tuser
// in_      slave      [15:0] sample           [0] sensor_index
// out_     master     [23:0] filtered (Q16.8) [0] channel, [1] first_sample
// cfg_     apb        0x0 outlier_threshold, 0x4 smoothing_factor
//
// A priming word fills its channel's window with the sample, one memory write a cycle.
// A later word is sorted by the single compare-swap unit doing W - W/2 bubble
// passes of W steps each.
// Reset is synchronous; all channels come up unprimed, no clearing pass.
// A stalled result holds in the output register while the next word runs.
`default_nettype none

module outlier_median_lowpass_filter #(
  parameter int WINDOW_SIZE = 5,
  parameter int NUM_SENSORS = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] sample
  input  wire logic [0:0]  in_tuser,   // [0] sensor_index
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [23:0] filtered
  output logic [1:0]       out_tuser,  // [0] channel, [1] first_sample
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int DEPTH  = NUM_SENSORS * WINDOW_SIZE;
  localparam int AW     = $clog2(DEPTH);
  localparam int PW     = $clog2(WINDOW_SIZE);
  localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
  localparam int NPASS  = WINDOW_SIZE - WINDOW_SIZE / 2;
  localparam int PASS_W = $clog2(NPASS);
  localparam int CH_W   = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(WINDOW_SIZE - 1);
  localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(WINDOW_SIZE);
  localparam logic [PW-1:0]     PTR_LAST = PW'(WINDOW_SIZE - 1);
  localparam logic [PASS_W-1:0] PASS_END = PASS_W'(NPASS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRIME,
    S_RD_PREV,
    S_CHK,
    S_LOAD,
    S_SORT,
    S_BLEND_GO,
    S_BLEND_WAIT,
    S_DONE
  } state_t;

  state_t                         state_r;
  logic [omlf_pkg::THR_W-1:0]     thr_r;
  logic [omlf_pkg::ALPHA_W-1:0]   alpha_r;
  logic [omlf_pkg::ALPHA_W-1:0]   alpha_nxt;
  logic [NUM_SENSORS-1:0]         primed_r;
  logic [omlf_pkg::FILT_W-1:0]    smooth_r [NUM_SENSORS];
  logic [PW-1:0]                  head_r   [NUM_SENSORS];
  logic [omlf_pkg::SAMPLE_W-1:0]  x_r;
  logic                           idx_r;
  logic [CH_W-1:0]                ch_r;
  logic [CH_W-1:0]                ch_in;
  logic [AW-1:0]                  base_r;
  logic [CNT_W-1:0]               cnt_r;
  logic [PASS_W-1:0]              pass_r;
  logic [omlf_pkg::FILT_W-1:0]    res_r;
  logic                           first_r;
  logic                           out_valid_r;
  logic [omlf_pkg::FILT_W-1:0]    out_data_r;
  logic [1:0]                     out_user_r;

  logic                           in_accept;
  logic                           out_load;
  logic                           cfg_wr;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [omlf_pkg::SAMPLE_W-1:0]  mem_wdata;
  logic                           mem_re;
  logic [AW-1:0]                  mem_raddr;
  logic [omlf_pkg::SAMPLE_W-1:0]  mem_rdata;
  logic [PW-1:0]                  head_cur;
  logic [PW-1:0]                  head_next;
  logic [omlf_pkg::SAMPLE_W-1:0]  diff;
  logic [omlf_pkg::SAMPLE_W-1:0]  new_sample;
  omlf_pkg::omlf_sort_ctl_t       sort_ctl;
  omlf_pkg::omlf_blend_req_t      blend_req;
  logic [omlf_pkg::SAMPLE_W-1:0]  median;
  logic                           blend_done;
  logic [omlf_pkg::FILT_W-1:0]    blend_res;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign ch_in      = (NUM_SENSORS > 1) ? CH_W'(in_tuser[0]) : '0;

  always_comb begin
    if (cfg_pwdata[16:0] > omlf_pkg::ALPHA_ONE) begin
      alpha_nxt = omlf_pkg::ALPHA_ONE;
    end else begin
      alpha_nxt = cfg_pwdata[16:0];
    end
    if (cfg_paddr[2] == omlf_pkg::REG_ALPHA) begin
      cfg_prdata = 32'(alpha_r);
    end else begin
      cfg_prdata = 32'(thr_r);
    end
  end

  always_comb begin
    head_cur  = head_r[ch_r];
    head_next = (head_cur == PTR_LAST) ? '0 : head_cur + 1'b1;
    if (x_r > mem_rdata) begin
      diff = x_r - mem_rdata;
    end else begin
      diff = mem_rdata - x_r;
    end
    new_sample = (diff > thr_r) ? mem_rdata : x_r;

    mem_we    = 1'b0;
    mem_waddr = base_r + AW'(cnt_r);
    mem_wdata = x_r;
    mem_re    = 1'b0;
    mem_raddr = base_r + AW'(cnt_r);
    sort_ctl  = '0;
    case (state_r)
      S_PRIME: begin
        mem_we = 1'b1;
      end
      S_RD_PREV: begin
        mem_re    = 1'b1;
        mem_raddr = base_r + AW'(head_cur);
      end
      S_CHK: begin
        mem_we    = 1'b1;
        mem_waddr = base_r + AW'(head_next);
        mem_wdata = new_sample;
      end
      S_LOAD: begin
        mem_re        = (cnt_r != CNT_END);
        sort_ctl.load = (cnt_r != '0);
      end
      S_SORT: begin
        sort_ctl.cmp = (cnt_r != CNT_LAST);
        sort_ctl.rot = (cnt_r == CNT_LAST);
      end
      default: begin
      end
    endcase

    blend_req.start  = (state_r == S_BLEND_GO);
    blend_req.alpha  = alpha_r;
    blend_req.median = median;
    blend_req.prev   = smooth_r[ch_r];
  end

  omlf_win_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_win_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  omlf_median #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_median (
    .clk    (clk),
    .ctl    (sort_ctl),
    .din    (mem_rdata),
    .median (median)
  );

  omlf_blend u_blend (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (blend_req),
    .done   (blend_done),
    .result (blend_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      thr_r       <= omlf_pkg::THR_RESET;
      alpha_r     <= omlf_pkg::ALPHA_RESET;
      primed_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[2] == omlf_pkg::REG_ALPHA) begin
          alpha_r <= alpha_nxt;
        end else begin
          thr_r <= cfg_pwdata[15:0];
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            x_r    <= in_tdata;
            idx_r  <= in_tuser[0];
            ch_r   <= ch_in;
            base_r <= AW'(ch_in * WINDOW_SIZE);
            cnt_r  <= '0;
            pass_r <= '0;
            state_r <= primed_r[ch_in] ? S_RD_PREV : S_PRIME;
          end
        end
        S_PRIME: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) begin
            primed_r[ch_r] <= 1'b1;
            head_r[ch_r]   <= '0;
            smooth_r[ch_r] <= {x_r, 8'h00};
            res_r          <= {x_r, 8'h00};
            first_r        <= 1'b1;
            state_r        <= S_DONE;
          end
        end
        S_RD_PREV: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          head_r[ch_r] <= head_next;
          state_r      <= S_LOAD;
        end
        S_LOAD: begin
          if (cnt_r == CNT_END) begin
            cnt_r   <= '0;
            state_r <= S_SORT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SORT: begin
          if (cnt_r == CNT_LAST) begin
            cnt_r <= '0;
            if (pass_r == PASS_END) begin
              state_r <= S_BLEND_GO;
            end else begin
              pass_r <= pass_r + 1'b1;
            end
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_BLEND_GO: begin
          state_r <= S_BLEND_WAIT;
        end
        S_BLEND_WAIT: begin
          if (blend_done) begin
            smooth_r[ch_r] <= blend_res;
            res_r          <= blend_res;
            first_r        <= 1'b0;
            state_r        <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_data_r <= res_r;
            out_user_r <= {first_r, idx_r};
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_alpha_sat: assert property (@(posedge clk) disable iff (!rst_n)
    alpha_r <= omlf_pkg::ALPHA_ONE)
    else $error("smoothing factor above one");

  a_first_whole: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> (out_tdata[7:0] == 8'h00))
    else $error("priming result has a fraction");

  a_blend_owned: assert property (@(posedge clk) disable iff (!rst_n)
    blend_done |-> (state_r == S_BLEND_WAIT))
    else $error("blend finished outside its wait state");

  a_unprimed_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !primed_r[ch_in]) |=> (state_r == S_PRIME))
    else $error("unprimed channel skipped priming");

endmodule

`default_nettype wire

// ===== rtl/omlf_win_ram.sv =====
// Sample window memory for all sensors, one write and one registered read port.
`default_nettype none

module omlf_win_ram #(
  parameter int DEPTH = 10,
  parameter int AW    = 4
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [AW-1:0]                 waddr,
  input  wire logic [omlf_pkg::SAMPLE_W-1:0] wdata,
  input  wire logic                          re,
  input  wire logic [AW-1:0]                 raddr,
  output logic      [omlf_pkg::SAMPLE_W-1:0] rdata
);

  logic [omlf_pkg::SAMPLE_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/omlf_median.sv =====
// Ring of window samples with one shared compare-swap unit for bubble passes.
`default_nettype none

module omlf_median #(
  parameter int WINDOW_SIZE = 5
) (
  input  wire logic                          clk,
  input  wire omlf_pkg::omlf_sort_ctl_t      ctl,
  input  wire logic [omlf_pkg::SAMPLE_W-1:0] din,
  output logic      [omlf_pkg::SAMPLE_W-1:0] median
);

  logic [omlf_pkg::SAMPLE_W-1:0] ring_r [WINDOW_SIZE];
  logic [omlf_pkg::SAMPLE_W-1:0] lo;
  logic [omlf_pkg::SAMPLE_W-1:0] hi;

  always_comb begin
    if (ring_r[0] > ring_r[1]) begin
      hi = ring_r[0];
      lo = ring_r[1];
    end else begin
      hi = ring_r[1];
      lo = ring_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
        ring_r[i] <= ring_r[i+1];
      end
      ring_r[WINDOW_SIZE-1] <= din;
    end else if (ctl.cmp) begin
      // carry the larger at the front, drop the smaller at the tail
      ring_r[0] <= hi;
      for (int i = 1; i < WINDOW_SIZE - 1; i++) begin
        ring_r[i] <= ring_r[i+1];
      end
      ring_r[WINDOW_SIZE-1] <= lo;
    end else if (ctl.rot) begin
      for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
        ring_r[i] <= ring_r[i+1];
      end
      ring_r[WINDOW_SIZE-1] <= ring_r[0];
    end
  end

  assign median = ring_r[WINDOW_SIZE/2];

endmodule

`default_nettype wire

// ===== rtl/omlf_blend.sv =====
// Exponential smoothing blend on one shared multiplier, used in turn by the MUL1 and MUL2 phases.
`default_nettype none

module omlf_blend (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire omlf_pkg::omlf_blend_req_t     req,
  output logic                               done,
  output logic      [omlf_pkg::FILT_W-1:0]   result
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL1,
    PH_MUL2,
    PH_DONE
  } ph_t;

  ph_t                           ph_r;
  logic [omlf_pkg::ACC_W-1:0]    acc_r;
  logic [omlf_pkg::ALPHA_W-1:0]  op_a;
  logic [omlf_pkg::FILT_W-1:0]   op_b;
  logic [omlf_pkg::ACC_W-1:0]    prod;

  always_comb begin
    if (ph_r == PH_MUL2) begin
      op_a = omlf_pkg::ALPHA_ONE - req.alpha;
      op_b = req.prev;
    end else begin
      op_a = req.alpha;
      op_b = {req.median, 8'h00};
    end
    prod = omlf_pkg::ACC_W'(op_a) * omlf_pkg::ACC_W'(op_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
    end else begin
      case (ph_r)
        PH_IDLE: begin
          if (req.start) begin
            ph_r <= PH_MUL1;
          end
        end
        PH_MUL1: begin
          acc_r <= prod + omlf_pkg::ROUND_HALF;
          ph_r  <= PH_MUL2;
        end
        PH_MUL2: begin
          acc_r <= acc_r + prod;
          ph_r  <= PH_DONE;
        end
        PH_DONE: begin
          ph_r <= PH_IDLE;
        end
        default: begin
          ph_r <= PH_IDLE;
        end
      endcase
    end
  end

  assign done   = (ph_r == PH_DONE);
  assign result = acc_r[omlf_pkg::FRAC_SH +: omlf_pkg::FILT_W];

endmodule

`default_nettype wire
